@@ sv/assert_macros.svh @@
// Assertion macros used by the checker module of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle, disabled while reset is active.
`define CHK_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Implication into the next cycle, disabled while reset is active.
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// Implication into the next cycle, checked during reset as well.
`define CHK_NEXT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/id3m_pkg.sv @@
// Shared types, constants and functions of the split entropy merit block.
package id3m_pkg;

  localparam int COUNT_BITS_DEF = 16;
  localparam int LOG_FRAC       = 24;
  localparam int MERIT_BITS     = 17;
  localparam int NUM_SLOTS      = 10;
  localparam int NUM_ATTR       = 4;
  localparam int QUEUE_DEPTH    = 2;
  localparam int SLOT_BITS      = $clog2(NUM_SLOTS);

  localparam logic [MERIT_BITS-1:0] MERIT_MAX = '1;

  localparam logic [1:0] ATTR_OUTLOOK     = 2'd0;
  localparam logic [1:0] ATTR_TEMPERATURE = 2'd1;
  localparam logic [1:0] ATTR_HUMIDITY    = 2'd2;
  localparam logic [1:0] ATTR_WIND        = 2'd3;

  localparam logic [1:0] OUTLOOK_UNREC  = 2'd3;
  localparam logic [1:0] TEMP_UNREC     = 2'd3;
  localparam logic [1:0] HUMIDITY_UNREC = 2'd2;

  localparam logic [SLOT_BITS-1:0] SLOT_OUTLOOK = SLOT_BITS'(0);
  localparam logic [SLOT_BITS-1:0] SLOT_TEMP    = SLOT_BITS'(3);
  localparam logic [SLOT_BITS-1:0] SLOT_HUM     = SLOT_BITS'(6);
  localparam logic [SLOT_BITS-1:0] SLOT_WINDY   = SLOT_BITS'(8);
  localparam logic [SLOT_BITS-1:0] SLOT_CALM    = SLOT_BITS'(9);

  typedef struct packed {
    logic [1:0] outlook;
    logic [1:0] temperature;
    logic [1:0] humidity;
    logic       windy;
    logic       positive_class;
    logic       last_record;
  } rec_t;

  typedef struct packed {
    logic [1:0]            attribute;
    logic [MERIT_BITS-1:0] merit;
    logic [1:0]            best_attribute;
    logic                  last_result;
  } res_t;

  function automatic logic [SLOT_BITS-1:0] slot_base(input logic [1:0] attr);
    logic [SLOT_BITS-1:0] b;
    case (attr)
      ATTR_OUTLOOK:     b = SLOT_OUTLOOK;
      ATTR_TEMPERATURE: b = SLOT_TEMP;
      ATTR_HUMIDITY:    b = SLOT_HUM;
      default:          b = SLOT_WINDY;
    endcase
    return b;
  endfunction

  function automatic logic [1:0] slot_last(input logic [1:0] attr);
    logic [1:0] l;
    case (attr)
      ATTR_OUTLOOK:     l = 2'd2;
      ATTR_TEMPERATURE: l = 2'd2;
      default:          l = 2'd1;
    endcase
    return l;
  endfunction

endpackage

@@ sv/id3m_front.sv @@
// Input side: takes records off the stream into a two-entry queue.
module id3m_front
  import id3m_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  rec_t in_rec,
  output rec_t rec,
  output logic rec_valid,
  input  logic rec_pop
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  rec_t            q_r [QUEUE_DEPTH];
  logic [PW-1:0]   wr_r;
  logic [PW-1:0]   rd_r;
  logic [PW:0]     cnt_r;
  logic            push;
  logic            pop;

  assign in_ready  = (cnt_r != (PW+1)'(QUEUE_DEPTH));
  assign rec_valid = (cnt_r != '0);
  assign rec       = q_r[rd_r];
  assign push      = in_valid && in_ready;
  assign pop       = rec_pop && rec_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_r] <= in_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= (wr_r == PW'(QUEUE_DEPTH-1)) ? '0 : wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= (rd_r == PW'(QUEUE_DEPTH-1)) ? '0 : rd_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

@@ sv/id3m_log2.sv @@
// Fixed-point base-two logarithm by normalisation and repeated squaring.
module id3m_log2
  import id3m_pkg::*;
#(
  parameter int XW = COUNT_BITS_DEF + 1
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [XW-1:0]                    x,
  output logic                             done,
  output logic [$clog2(XW)+LOG_FRAC-1:0]   y
);

  localparam int EW = $clog2(XW);
  localparam int SW = XW + 32;

  typedef enum logic [3:0] {
    L_IDLE = 4'b0001,
    L_NORM = 4'b0010,
    L_SQR  = 4'b0100,
    L_DONE = 4'b1000
  } lst_t;

  lst_t                 state_r;
  logic [SW-1:0]        xs_r;
  logic [EW-1:0]        e_r;
  logic [31:0]          m_r;
  logic [LOG_FRAC-1:0]  frac_r;
  logic [4:0]           it_r;
  logic [63:0]          sq;

  assign sq   = m_r * m_r;
  assign done = (state_r == L_DONE);
  assign y    = {e_r, frac_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
    end else begin
      case (state_r)
        L_IDLE: begin
          if (start) begin
            xs_r    <= {x, 32'b0};
            e_r     <= EW'(XW-1);
            frac_r  <= '0;
            state_r <= L_NORM;
          end
        end
        L_NORM: begin
          if (xs_r[SW-1]) begin
            m_r     <= xs_r[SW-1 -: 32];
            it_r    <= '0;
            state_r <= L_SQR;
          end else begin
            xs_r <= {xs_r[SW-2:0], 1'b0};
            e_r  <= e_r - 1'b1;
          end
        end
        L_SQR: begin
          if (sq[63]) begin
            m_r    <= sq[63:32];
            frac_r <= {frac_r[LOG_FRAC-2:0], 1'b1};
          end else begin
            m_r    <= sq[62:31];
            frac_r <= {frac_r[LOG_FRAC-2:0], 1'b0};
          end
          it_r <= it_r + 1'b1;
          if (it_r == 5'(LOG_FRAC-1)) begin
            state_r <= L_DONE;
          end
        end
        L_DONE: begin
          state_r <= L_IDLE;
        end
        default: begin
          state_r <= L_IDLE;
        end
      endcase
    end
  end

endmodule

@@ sv/id3m_div.sv @@
// Restoring divider, one quotient bit per cycle, result saturated to the merit range.
module id3m_div
  import id3m_pkg::*;
#(
  parameter int DW = 64,
  parameter int NW = COUNT_BITS_DEF + 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DW-1:0]         dividend,
  input  logic [NW-1:0]         divisor,
  output logic                  done,
  output logic [MERIT_BITS-1:0] q
);

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] quo_r;
  logic [NW-1:0] rem_r;
  logic [NW-1:0] d_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [NW:0]   trial;
  logic          fits;

  assign trial = {rem_r, quo_r[DW-1]};
  assign fits  = (trial >= {1'b0, d_r});
  assign done  = done_r;
  assign q     = (|quo_r[DW-1:MERIT_BITS]) ? MERIT_MAX : quo_r[MERIT_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        quo_r  <= dividend;
        rem_r  <= '0;
        d_r    <= divisor;
        cnt_r  <= CW'(DW);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= fits ? NW'(trial - {1'b0, d_r}) : trial[NW-1:0];
        quo_r <= {quo_r[DW-2:0], fits};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

@@ sv/id3m_back.sv @@
// Record counters, entropy sequencer and result register.
module id3m_back
  import id3m_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  rec_t rec,
  input  logic rec_valid,
  output logic rec_pop,
  output res_t out_data,
  output logic out_valid,
  input  logic out_ready
);

  localparam int XW = COUNT_BITS + 1;
  localparam int EW = $clog2(XW);
  localparam int LW = EW + LOG_FRAC;
  localparam int PW = COUNT_BITS + LW;
  localparam int SW = PW + 3;
  localparam int DW = SW + 1;
  localparam int NW = COUNT_BITS + 8;
  localparam logic [COUNT_BITS-1:0] CMAX = '1;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SLOT = 7'b0000010,
    S_LOG  = 7'b0000100,
    S_ACC  = 7'b0001000,
    S_NEXT = 7'b0010000,
    S_DIV  = 7'b0100000,
    S_EMIT = 7'b1000000
  } st_t;

  typedef enum logic [1:0] {
    W_A = 2'd0,
    W_P = 2'd1,
    W_N = 2'd2
  } which_t;

  st_t                     state_r;
  which_t                  which_r;
  logic [COUNT_BITS-1:0]   pos_r [NUM_SLOTS];
  logic [COUNT_BITS-1:0]   neg_r [NUM_SLOTS];
  logic [COUNT_BITS-1:0]   total_r;
  logic [1:0]              attr_r;
  logic [SLOT_BITS-1:0]    slot_r;
  logic [1:0]              scnt_r;
  logic [LW-1:0]           la_r;
  logic [PW-1:0]           prod_r;
  logic [SW-1:0]           sum_r;
  logic [MERIT_BITS-1:0]   merit_r [NUM_ATTR];
  logic [1:0]              best_r;
  logic [MERIT_BITS-1:0]   bestm_r;
  logic [1:0]              emit_r;
  logic                    log_start_r;
  logic [XW-1:0]           log_x_r;
  logic                    div_start_r;
  logic [DW-1:0]           div_n_r;
  logic [NW-1:0]           div_d_r;
  logic                    out_valid_r;
  res_t                    out_data_r;

  logic [NUM_SLOTS-1:0]    hit;
  logic [COUNT_BITS-1:0]   p;
  logic [COUNT_BITS-1:0]   n;
  logic [XW-1:0]           a;
  logic [COUNT_BITS-1:0]   c;
  logic [LW-1:0]           diff;
  logic [PW-1:0]           mul;
  logic                    log_done;
  logic [LW-1:0]           log_y;
  logic                    div_done;
  logic [MERIT_BITS-1:0]   div_q;

  assign p         = pos_r[slot_r];
  assign n         = neg_r[slot_r];
  assign a         = {1'b0, p} + {1'b0, n};
  assign c         = (which_r == W_P) ? p : n;
  assign diff      = la_r - log_y;
  assign mul       = PW'(c) * PW'(diff);
  assign rec_pop   = (state_r == S_IDLE) && rec_valid;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    hit = '0;
    if (rec.outlook != OUTLOOK_UNREC) begin
      hit[SLOT_OUTLOOK + SLOT_BITS'(rec.outlook)] = 1'b1;
    end
    if (rec.temperature != TEMP_UNREC) begin
      hit[SLOT_TEMP + SLOT_BITS'(rec.temperature)] = 1'b1;
    end
    if (rec.humidity < HUMIDITY_UNREC) begin
      hit[SLOT_HUM + SLOT_BITS'(rec.humidity)] = 1'b1;
    end
    hit[rec.windy ? SLOT_WINDY : SLOT_CALM] = 1'b1;
  end

  id3m_log2 #(
    .XW (XW)
  ) u_log (
    .clk   (clk),
    .rst_n (rst_n),
    .start (log_start_r),
    .x     (log_x_r),
    .done  (log_done),
    .y     (log_y)
  );

  id3m_div #(
    .DW (DW),
    .NW (NW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_r),
    .dividend (div_n_r),
    .divisor  (div_d_r),
    .done     (div_done),
    .q        (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      which_r     <= W_A;
      log_start_r <= 1'b0;
      div_start_r <= 1'b0;
      out_valid_r <= 1'b0;
      total_r     <= '0;
      for (int s = 0; s < NUM_SLOTS; s++) begin
        pos_r[s] <= '0;
        neg_r[s] <= '0;
      end
    end else begin
      log_start_r <= 1'b0;
      div_start_r <= 1'b0;
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (rec_valid) begin
            if (total_r != CMAX) begin
              total_r <= total_r + 1'b1;
            end
            for (int s = 0; s < NUM_SLOTS; s++) begin
              if (hit[s] && rec.positive_class && pos_r[s] != CMAX) begin
                pos_r[s] <= pos_r[s] + 1'b1;
              end
              if (hit[s] && !rec.positive_class && neg_r[s] != CMAX) begin
                neg_r[s] <= neg_r[s] + 1'b1;
              end
            end
            if (rec.last_record) begin
              attr_r  <= ATTR_OUTLOOK;
              slot_r  <= slot_base(ATTR_OUTLOOK);
              scnt_r  <= '0;
              sum_r   <= '0;
              state_r <= S_SLOT;
            end
          end
        end
        S_SLOT: begin
          if (a == '0) begin
            state_r <= S_NEXT;
          end else begin
            log_start_r <= 1'b1;
            log_x_r     <= a;
            which_r     <= W_A;
            state_r     <= S_LOG;
          end
        end
        S_LOG: begin
          if (log_done) begin
            if (which_r == W_A) begin
              la_r        <= log_y;
              log_start_r <= 1'b1;
              if (p != '0) begin
                which_r <= W_P;
                log_x_r <= {1'b0, p};
              end else begin
                which_r <= W_N;
                log_x_r <= {1'b0, n};
              end
            end else begin
              prod_r  <= (la_r > log_y) ? mul : '0;
              state_r <= S_ACC;
            end
          end
        end
        S_ACC: begin
          sum_r <= sum_r + SW'(prod_r);
          if (which_r == W_P && n != '0) begin
            which_r     <= W_N;
            log_start_r <= 1'b1;
            log_x_r     <= {1'b0, n};
            state_r     <= S_LOG;
          end else begin
            state_r <= S_NEXT;
          end
        end
        S_NEXT: begin
          if (scnt_r == slot_last(attr_r)) begin
            div_start_r <= 1'b1;
            div_n_r     <= DW'(sum_r) + (DW'(total_r) << 7);
            div_d_r     <= {total_r, 8'b0};
            state_r     <= S_DIV;
          end else begin
            slot_r  <= slot_r + 1'b1;
            scnt_r  <= scnt_r + 1'b1;
            state_r <= S_SLOT;
          end
        end
        S_DIV: begin
          if (div_done) begin
            merit_r[attr_r] <= div_q;
            if (attr_r == ATTR_OUTLOOK || div_q < bestm_r) begin
              best_r  <= attr_r;
              bestm_r <= div_q;
            end
            if (attr_r == ATTR_WIND) begin
              emit_r  <= ATTR_OUTLOOK;
              state_r <= S_EMIT;
            end else begin
              attr_r  <= attr_r + 1'b1;
              slot_r  <= slot_base(attr_r + 1'b1);
              scnt_r  <= '0;
              sum_r   <= '0;
              state_r <= S_SLOT;
            end
          end
        end
        S_EMIT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r                <= 1'b1;
            out_data_r.attribute       <= emit_r;
            out_data_r.merit           <= merit_r[emit_r];
            out_data_r.best_attribute  <= best_r;
            out_data_r.last_result     <= (emit_r == ATTR_WIND);
            emit_r                     <= emit_r + 1'b1;
            if (emit_r == ATTR_WIND) begin
              total_r <= '0;
              for (int s = 0; s < NUM_SLOTS; s++) begin
                pos_r[s] <= '0;
                neg_r[s] <= '0;
              end
              state_r <= S_IDLE;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ sv/id3_split_entropy_merit.sv @@
// Records are counted at one per cycle behind a two-entry input queue, so the block takes a
// new record every cycle while it is counting. The record marked last starts the merit
// sequence: for each category with records, the shared logarithm unit is run for the category
// total and for each non-zero class count, and each attribute then needs one restoring
// division. The four results then leave in attribute order, after which the next run's
// records are taken again.
module id3_split_entropy_merit
  import id3m_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // outlook[1:0], temperature[3:2], humidity[5:4],
                                  // windy[6], positive_class[7]
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // attribute[1:0], merit[18:2], best_attribute[20:19],
                                  // zero[23:21]
  output logic        out_tlast
);

  rec_t in_rec;
  rec_t rec;
  logic rec_valid;
  logic rec_pop;
  res_t res;

  assign in_rec.outlook        = in_tdata[1:0];
  assign in_rec.temperature    = in_tdata[3:2];
  assign in_rec.humidity       = in_tdata[5:4];
  assign in_rec.windy          = in_tdata[6];
  assign in_rec.positive_class = in_tdata[7];
  assign in_rec.last_record    = in_tlast;

  id3m_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_rec    (in_rec),
    .rec       (rec),
    .rec_valid (rec_valid),
    .rec_pop   (rec_pop)
  );

  id3m_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .rec       (rec),
    .rec_valid (rec_valid),
    .rec_pop   (rec_pop),
    .out_data  (res),
    .out_valid (out_tvalid),
    .out_ready (out_tready)
  );

  assign out_tdata = {3'b000, res.best_attribute, res.merit, res.attribute};
  assign out_tlast = res.last_result;

endmodule

@@ sv/id3m_checker.sv @@
// Port checker for the split entropy merit block and its binding.
`include "assert_macros.svh"

module id3m_checker
  import id3m_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tlast
);

  `CHK_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid, "result request dropped while stalled")
  `CHK_SAME(a_last_wind, out_tvalid, (out_tdata[1:0] == ATTR_WIND) == out_tlast, "last mark not on wind")
  `CHK_SAME(a_pad_zero, out_tvalid, out_tdata[23:21] == 3'd0, "result padding not zero")
  `CHK_NEXT_ALWAYS(a_rst_idle, !rst_n, !out_tvalid, "result request after reset")

endmodule

bind id3_split_entropy_merit id3m_checker u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
